// ===== hdl/ddhs_pkg.sv =====
package ddhs_pkg;

    // Field widths
    localparam int DW        = 25;     // position difference, signed
    localparam int VW        = 28;     // vectoring CORDIC x/y
    localparam int ZW        = 32;     // CORDIC angle accumulator
    localparam int RW        = 32;     // rotation CORDIC x/y/z
    localparam int CW        = 18;     // cosine, signed Q16
    localparam int SQ_DIGITS = 25;     // result bits of the distance square root
    localparam int SQ_NW     = 51;     // square root remainder width
    localparam int SQ_LAT    = SQ_DIGITS + 2;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int CORDIC_STEPS_MAX = 24;

    // Arithmetic constants
    localparam logic signed [RW-1:0] C_COS_INIT  = 32'sd652032875;
    localparam logic [15:0]          C_QUARTER   = 16'd16384;
    localparam logic [16:0]          C_COS_FLOOR = 17'd9830;
    localparam logic [15:0]          C_V_FLOOR   = 16'd256;
    localparam logic [8:0]           C_CAP_GAIN  = 9'd300;
    localparam logic [16:0]          C_DIFF_GAIN = 17'd80425;
    localparam logic [64:0]          C_DIFF_RND  = 65'h800_0000_0000;

    typedef enum logic [2:0] {
        CFG_HARD_TURN = 3'd0,
        CFG_PIVOT     = 3'd1,
        CFG_CRUISE    = 3'd2,
        CFG_GAIN      = 3'd3,
        CFG_AXLE      = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] hard_turn_angle;
        logic [14:0] pivot_speed;
        logic [14:0] cruise_speed;
        logic [15:0] heading_gain;
        logic [15:0] axle_length;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        hard_turn_angle: 16'd10012,
        pivot_speed:     15'd768,
        cruise_speed:    15'd2560,
        heading_gain:    16'd4096,
        axle_length:     16'd9175
    };

    // atan(2^-i) in units of 2pi/2^32
    function automatic logic [ZW-1:0] atan_ent(input int unsigned i);
        logic [ZW-1:0] a;
        case (i)
            0:  a = 32'h20000000;
            1:  a = 32'h12E4051E;
            2:  a = 32'h09FB385B;
            3:  a = 32'h051111D4;
            4:  a = 32'h028B0D43;
            5:  a = 32'h0145D7E1;
            6:  a = 32'h00A2F61E;
            7:  a = 32'h00517C55;
            8:  a = 32'h0028BE53;
            9:  a = 32'h00145F2F;
            10: a = 32'h000A2F98;
            11: a = 32'h000517CC;
            12: a = 32'h00028BE6;
            13: a = 32'h000145F3;
            14: a = 32'h0000A2FA;
            15: a = 32'h0000517D;
            16: a = 32'h000028BE;
            17: a = 32'h0000145F;
            18: a = 32'h00000A30;
            19: a = 32'h00000518;
            20: a = 32'h0000028C;
            21: a = 32'h00000146;
            22: a = 32'h000000A3;
            23: a = 32'h00000051;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// ===== hdl/ddhs_dly.sv =====
module ddhs_dly #(
    parameter int W = 1,
    parameter int N = 0
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_valid,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    output logic [W-1:0] o_data
);
    generate
        if (N == 0) begin : g_none
            assign o_valid = i_valid;
            assign o_data  = i_data;
        end else begin : g_line
            logic [W-1:0] r_sr [0:N-1];
            logic [N-1:0] r_v;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v <= '0;
                end else if (i_en) begin
                    r_v <= N'({r_v, i_valid});
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_sr[0] <= i_data;
                    for (int k = 1; k < N; k++) begin
                        r_sr[k] <= r_sr[k-1];
                    end
                end
            end

            assign o_valid = r_v[N-1];
            assign o_data  = r_sr[N-1];
        end
    endgenerate
endmodule

// ===== hdl/ddhs_sqrt.sv =====
module ddhs_sqrt (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [ddhs_pkg::DW-1:0]       i_dx,
    input  logic signed [ddhs_pkg::DW-1:0]       i_dy,
    output logic        [ddhs_pkg::SQ_DIGITS-1:0] o_dist
);
    import ddhs_pkg::*;

    logic [2*DW-1:0] r_sx, r_sy;
    logic [SQ_NW-1:0] r_n;
    logic [SQ_NW-1:0] w_n [0:SQ_DIGITS];
    logic [SQ_NW-1:0] w_r [0:SQ_DIGITS];

    // square both offsets, then sum
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sx <= 50'(50'(i_dx) * 50'(i_dx));
            r_sy <= 50'(50'(i_dy) * 50'(i_dy));
            r_n  <= SQ_NW'(r_sx) + SQ_NW'(r_sy);
        end
    end

    assign w_n[0] = r_n;
    assign w_r[0] = '0;

    // one result bit per stage, highest first
    generate
        for (genvar k = 0; k < SQ_DIGITS; k++) begin : g_dg
            localparam logic [SQ_NW-1:0] BIT = SQ_NW'(1) << (2 * (SQ_DIGITS - 1 - k));
            logic [SQ_NW-1:0] r_nn, r_rr, n_nn, n_rr, n_t;

            always_comb begin
                n_t = w_r[k] + BIT;
                if (w_n[k] >= n_t) begin
                    n_nn = w_n[k] - n_t;
                    n_rr = (w_r[k] >> 1) + BIT;
                end else begin
                    n_nn = w_n[k];
                    n_rr = w_r[k] >> 1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_nn <= n_nn;
                    r_rr <= n_rr;
                end
            end

            assign w_n[k+1] = r_nn;
            assign w_r[k+1] = r_rr;
        end
    endgenerate

    assign o_dist = w_r[SQ_DIGITS][SQ_DIGITS-1:0];
endmodule

// ===== hdl/ddhs_vec.sv =====
module ddhs_vec #(
    parameter int STEPS = ddhs_pkg::CORDIC_STEPS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic signed [ddhs_pkg::DW-1:0] i_dx,
    input  logic signed [ddhs_pkg::DW-1:0] i_dy,
    input  logic        [15:0]             i_yaw,
    input  logic                           i_fin,
    output logic                           o_valid,
    output logic signed [15:0]             o_err,
    output logic                           o_fin
);
    import ddhs_pkg::*;

    logic signed [VW-1:0] w_x [0:STEPS];
    logic signed [VW-1:0] w_y [0:STEPS];
    logic        [ZW-1:0] w_z [0:STEPS];
    logic [15:0]          w_yaw [0:STEPS];
    logic                 w_zero [0:STEPS];
    logic                 w_fin [0:STEPS];
    logic                 w_v [0:STEPS];

    logic signed [VW-1:0] r_x0, r_y0, n_x0, n_y0;
    logic        [ZW-1:0] r_z0, n_z0;
    logic [15:0]          r_yaw0;
    logic                 r_zero0, r_fin0, r_v0;

    // fold the left half plane over by half a turn
    always_comb begin
        if (i_dx < 0) begin
            n_x0 = -VW'(i_dx);
            n_y0 = -VW'(i_dy);
            n_z0 = 32'h8000_0000;
        end else begin
            n_x0 = VW'(i_dx);
            n_y0 = VW'(i_dy);
            n_z0 = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (i_en) begin
            r_v0 <= i_valid;
        end
        if (i_en) begin
            r_x0    <= n_x0;
            r_y0    <= n_y0;
            r_z0    <= n_z0;
            r_yaw0  <= i_yaw;
            r_zero0 <= (i_dx == '0) && (i_dy == '0);
            r_fin0  <= i_fin;
        end
    end

    assign w_x[0]    = r_x0;
    assign w_y[0]    = r_y0;
    assign w_z[0]    = r_z0;
    assign w_yaw[0]  = r_yaw0;
    assign w_zero[0] = r_zero0;
    assign w_fin[0]  = r_fin0;
    assign w_v[0]    = r_v0;

    generate
        for (genvar i = 0; i < STEPS; i++) begin : g_it
            logic signed [VW-1:0] r_x, r_y, n_x, n_y;
            logic        [ZW-1:0] r_z, n_z;
            logic [15:0]          r_yaw;
            logic                 r_zero, r_fin, r_v;

            // drive y toward zero
            always_comb begin
                if (w_y[i] > 0) begin
                    n_x = w_x[i] + (w_y[i] >>> i);
                    n_y = w_y[i] - (w_x[i] >>> i);
                    n_z = w_z[i] + atan_ent(i);
                end else begin
                    n_x = w_x[i] - (w_y[i] >>> i);
                    n_y = w_y[i] + (w_x[i] >>> i);
                    n_z = w_z[i] - atan_ent(i);
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v <= 1'b0;
                end else if (i_en) begin
                    r_v <= w_v[i];
                end
                if (i_en) begin
                    r_x    <= n_x;
                    r_y    <= n_y;
                    r_z    <= n_z;
                    r_yaw  <= w_yaw[i];
                    r_zero <= w_zero[i];
                    r_fin  <= w_fin[i];
                end
            end

            assign w_x[i+1]    = r_x;
            assign w_y[i+1]    = r_y;
            assign w_z[i+1]    = r_z;
            assign w_yaw[i+1]  = r_yaw;
            assign w_zero[i+1] = r_zero;
            assign w_fin[i+1]  = r_fin;
            assign w_v[i+1]    = r_v;
        end
    endgenerate

    logic [ZW-1:0] n_bsum;
    logic [15:0]   n_bear;
    logic [15:0]   r_err;
    logic          r_fin, r_v;

    // round bearing to 16 bits and subtract yaw, wrapping
    always_comb begin
        n_bsum = w_z[STEPS] + 32'h0000_8000;
        n_bear = w_zero[STEPS] ? 16'd0 : n_bsum[31:16];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= w_v[STEPS];
        end
        if (i_en) begin
            r_err <= n_bear - w_yaw[STEPS];
            r_fin <= w_fin[STEPS];
        end
    end

    assign o_valid = r_v;
    assign o_err   = $signed(r_err);
    assign o_fin   = r_fin;
endmodule

// ===== hdl/ddhs_cos.sv =====
module ddhs_cos #(
    parameter int STEPS = ddhs_pkg::CORDIC_STEPS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic signed [15:0]             i_err,
    input  logic                           i_fin,
    output logic                           o_valid,
    output logic signed [ddhs_pkg::CW-1:0] o_cos,
    output logic signed [15:0]             o_err,
    output logic                           o_fin
);
    import ddhs_pkg::*;

    logic signed [RW-1:0] w_x [0:STEPS];
    logic signed [RW-1:0] w_y [0:STEPS];
    logic signed [RW-1:0] w_z [0:STEPS];
    logic signed [15:0]   w_err [0:STEPS];
    logic                 w_fin [0:STEPS];
    logic                 w_v [0:STEPS];

    logic [15:0]          n_mag;
    logic signed [RW-1:0] r_z0, n_z0;
    logic signed [15:0]   r_err0;
    logic                 r_fin0, r_v0;

    // start angle is |err|; a quarter turn or more is not rotated
    always_comb begin
        n_mag = i_err[15] ? 16'(-i_err) : 16'(i_err);
        if (n_mag >= C_QUARTER) begin
            n_z0 = '0;
        end else begin
            n_z0 = $signed({2'b00, n_mag[13:0], 16'h0000});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (i_en) begin
            r_v0 <= i_valid;
        end
        if (i_en) begin
            r_z0   <= n_z0;
            r_err0 <= i_err;
            r_fin0 <= i_fin;
        end
    end

    assign w_x[0]   = C_COS_INIT;
    assign w_y[0]   = '0;
    assign w_z[0]   = r_z0;
    assign w_err[0] = r_err0;
    assign w_fin[0] = r_fin0;
    assign w_v[0]   = r_v0;

    generate
        for (genvar i = 0; i < STEPS; i++) begin : g_it
            logic signed [RW-1:0] r_x, r_y, r_z, n_x, n_y, n_z;
            logic signed [15:0]   r_err;
            logic                 r_fin, r_v;

            // rotate toward zero residual angle
            always_comb begin
                if (w_z[i] >= 0) begin
                    n_x = w_x[i] - (w_y[i] >>> i);
                    n_y = w_y[i] + (w_x[i] >>> i);
                    n_z = w_z[i] - $signed(atan_ent(i));
                end else begin
                    n_x = w_x[i] + (w_y[i] >>> i);
                    n_y = w_y[i] - (w_x[i] >>> i);
                    n_z = w_z[i] + $signed(atan_ent(i));
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v <= 1'b0;
                end else if (i_en) begin
                    r_v <= w_v[i];
                end
                if (i_en) begin
                    r_x   <= n_x;
                    r_y   <= n_y;
                    r_z   <= n_z;
                    r_err <= w_err[i];
                    r_fin <= w_fin[i];
                end
            end

            assign w_x[i+1]   = r_x;
            assign w_y[i+1]   = r_y;
            assign w_z[i+1]   = r_z;
            assign w_err[i+1] = r_err;
            assign w_fin[i+1] = r_fin;
            assign w_v[i+1]   = r_v;
        end
    endgenerate

    assign o_valid = w_v[STEPS];
    assign o_cos   = CW'(w_x[STEPS] >>> 14);
    assign o_err   = w_err[STEPS];
    assign o_fin   = w_fin[STEPS];
endmodule

// ===== hdl/ddhs_out.sv =====
module ddhs_out (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  ddhs_pkg::t_cfg                        i_cfg,
    input  logic                                  i_valid,
    input  logic signed [ddhs_pkg::CW-1:0]        i_cos,
    input  logic signed [15:0]                    i_err,
    input  logic                                  i_fin,
    input  logic        [ddhs_pkg::SQ_DIGITS-1:0] i_dist,
    output logic                                  o_valid,
    output logic signed [15:0]                    o_left,
    output logic signed [15:0]                    o_right,
    output logic                                  o_piv
);
    import ddhs_pkg::*;

    // ---- stage A: speed scale, distance cap, gain product, pivot decision
    logic [15:0]        n_mag;
    logic [16:0]        n_c;
    logic [31:0]        n_vp;
    logic [33:0]        n_cp;
    logic signed [15:0] n_ps;
    logic               r_a_v, r_a_fin, r_a_piv;
    logic [15:0]        r_a_vel, r_a_mag;
    logic [25:0]        r_a_cap;
    logic [31:0]        r_a_gk;
    logic               r_a_neg;
    logic signed [15:0] r_a_ps;

    always_comb begin
        n_mag = i_err[15] ? 16'(-i_err) : 16'(i_err);
        if (n_mag >= C_QUARTER || i_cos < $signed({1'b0, C_COS_FLOOR})) begin
            n_c = C_COS_FLOOR;
        end else begin
            n_c = i_cos[16:0];
        end
        n_vp = 32'(i_cfg.cruise_speed) * 32'(n_c);
        n_cp = 34'(i_dist) * 34'(C_CAP_GAIN);
        if (!i_err[15] && i_err != '0) begin
            n_ps = $signed({1'b0, i_cfg.pivot_speed});
        end else begin
            n_ps = -$signed({1'b0, i_cfg.pivot_speed});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (i_en) begin
            r_a_v <= i_valid;
        end
        if (i_en) begin
            r_a_vel <= n_vp[31:16];
            r_a_cap <= n_cp[33:8];
            r_a_gk  <= 32'(i_cfg.heading_gain) * 32'(i_cfg.axle_length);
            r_a_mag <= n_mag;
            r_a_neg <= i_err[15];
            r_a_fin <= i_fin;
            r_a_piv <= n_mag > i_cfg.hard_turn_angle;
            r_a_ps  <= n_ps;
        end
    end

    // ---- stage B: brake and floor the forward speed, scale by |err|
    logic [15:0]        n_bv;
    logic               r_b_v, r_b_neg, r_b_piv;
    logic [15:0]        r_b_vel;
    logic [47:0]        r_b_p;
    logic signed [15:0] r_b_ps;

    always_comb begin
        n_bv = r_a_vel;
        if (r_a_fin && r_a_cap < 26'(r_a_vel)) begin
            n_bv = r_a_cap[15:0];
        end
        if (n_bv < C_V_FLOOR) begin
            n_bv = C_V_FLOOR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (i_en) begin
            r_b_v <= r_a_v;
        end
        if (i_en) begin
            r_b_vel <= n_bv;
            r_b_p   <= 48'(r_a_gk) * 48'(r_a_mag);
            r_b_neg <= r_a_neg;
            r_b_piv <= r_a_piv;
            r_b_ps  <= r_a_ps;
        end
    end

    // ---- stage C: split constant multiply in two halves
    logic               r_c_v, r_c_neg, r_c_piv;
    logic [15:0]        r_c_vel;
    logic [40:0]        r_c_ph, r_c_pl;
    logic signed [15:0] r_c_ps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (i_en) begin
            r_c_v <= r_b_v;
        end
        if (i_en) begin
            r_c_ph  <= 41'(r_b_p[47:24]) * 41'(C_DIFF_GAIN);
            r_c_pl  <= 41'(r_b_p[23:0]) * 41'(C_DIFF_GAIN);
            r_c_vel <= r_b_vel;
            r_c_neg <= r_b_neg;
            r_c_piv <= r_b_piv;
            r_c_ps  <= r_b_ps;
        end
    end

    // ---- stage D: round the differential term, split the wheels
    logic [64:0]        n_sum;
    logic signed [21:0] n_diff;
    logic               r_d_v, r_d_piv;
    logic signed [23:0] r_d_vl, r_d_vr;
    logic signed [15:0] r_d_ps;

    always_comb begin
        n_sum  = {r_c_ph, 24'h000000} + 65'(r_c_pl) + C_DIFF_RND;
        n_diff = r_c_neg ? -$signed({1'b0, n_sum[64:44]}) : $signed({1'b0, n_sum[64:44]});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else if (i_en) begin
            r_d_v <= r_c_v;
        end
        if (i_en) begin
            r_d_vl  <= $signed({8'h00, r_c_vel}) - 24'(n_diff);
            r_d_vr  <= $signed({8'h00, r_c_vel}) + 24'(n_diff);
            r_d_piv <= r_c_piv;
            r_d_ps  <= r_c_ps;
        end
    end

    // ---- stage E: pull both wheels down by the excess over cruise
    logic signed [23:0] n_cr, n_mx, n_over;
    logic               r_e_v, r_e_piv;
    logic signed [23:0] r_e_vl, r_e_vr;
    logic signed [15:0] r_e_ps;

    always_comb begin
        n_cr   = $signed({9'h000, i_cfg.cruise_speed});
        n_mx   = (r_d_vl > r_d_vr) ? r_d_vl : r_d_vr;
        n_over = n_mx - n_cr;
        if (n_over < 0) begin
            n_over = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
        end else if (i_en) begin
            r_e_v <= r_d_v;
        end
        if (i_en) begin
            r_e_vl  <= r_d_vl - n_over;
            r_e_vr  <= r_d_vr - n_over;
            r_e_piv <= r_d_piv;
            r_e_ps  <= r_d_ps;
        end
    end

    // ---- stage F: clamp each wheel and pick pivot or drive
    logic signed [23:0] n_fl, n_fr;
    logic               r_f_v, r_f_piv;
    logic signed [15:0] r_f_l, r_f_r;

    always_comb begin
        n_fl = r_e_vl;
        n_fr = r_e_vr;
        if (n_fl > n_cr)  n_fl = n_cr;
        if (n_fl < -n_cr) n_fl = -n_cr;
        if (n_fr > n_cr)  n_fr = n_cr;
        if (n_fr < -n_cr) n_fr = -n_cr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else if (i_en) begin
            r_f_v <= r_e_v;
        end
        if (i_en) begin
            r_f_l   <= r_e_piv ? -r_e_ps : n_fl[15:0];
            r_f_r   <= r_e_piv ? r_e_ps : n_fr[15:0];
            r_f_piv <= r_e_piv;
        end
    end

    assign o_valid = r_f_v;
    assign o_left  = r_f_l;
    assign o_right = r_f_r;
    assign o_piv   = r_f_piv;
endmodule

// ===== hdl/differential_drive_heading_steer_top.sv =====
// Differential-drive heading steer.
// Input channel (i_in_valid / o_in_ready): one beat carries the target point,
// the pose estimate and the final-cell flag. Output channel (o_out_valid /
// i_out_ready): one beat per input beat with both wheel speeds and the pivot
// flag, in input order.
// Configuration channel (i_cfg_valid / o_cfg_ready, always ready): index 0..4
// selects hard turn angle, pivot speed, cruise speed, heading gain, axle
// length; other indexes are dropped. Write only while the pipe is empty.
// Throughput: one beat per cycle while i_out_ready does not hold the pipe.
// The delay from acceptance to o_out_valid is set by the two CORDIC pipes in
// series (bearing, then cosine) against the 25-digit distance square root
// running beside them.
// Reset: valid bits clear, the configuration registers return to their
// defaults; no beat is in flight afterwards.
// Stall: the whole pipe holds while a result waits and i_out_ready is low;
// input is still taken whenever the output register is empty or draining.
module differential_drive_heading_steer_top #(
    parameter int CORDIC_STEPS = ddhs_pkg::CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [23:0] i_target_x,
    input  logic signed [23:0] i_target_y,
    input  logic signed [23:0] i_pose_x,
    input  logic signed [23:0] i_pose_y,
    input  logic        [15:0] i_pose_yaw,
    input  logic               i_final_cell,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_left_speed,
    output logic signed [15:0] o_right_speed,
    output logic               o_pivoting,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic        [2:0]  i_cfg_index,
    input  logic        [15:0] i_cfg_data
);
    import ddhs_pkg::*;

    localparam int STEPS   = (CORDIC_STEPS < CORDIC_STEPS_MAX) ? CORDIC_STEPS
                                                               : CORDIC_STEPS_MAX;
    localparam int LAT_ANG = 2 * STEPS + 3;
    localparam int D_SQ    = (LAT_ANG > SQ_LAT) ? LAT_ANG - SQ_LAT : 0;
    localparam int D_ANG   = (SQ_LAT > LAT_ANG) ? SQ_LAT - LAT_ANG : 0;
    localparam int AW      = CW + 16 + 1;

    // Whole pipe advances together; it only holds when the output beat
    // is stuck.
    logic w_en;
    assign w_en        = !o_out_valid || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_cfg_ready = 1'b1;

    // Configuration registers
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HARD_TURN: r_cfg.hard_turn_angle <= i_cfg_data;
                CFG_PIVOT:     r_cfg.pivot_speed     <= i_cfg_data[14:0];
                CFG_CRUISE:    r_cfg.cruise_speed    <= i_cfg_data[14:0];
                CFG_GAIN:      r_cfg.heading_gain    <= i_cfg_data;
                CFG_AXLE:      r_cfg.axle_length     <= i_cfg_data;
                default:       r_cfg <= r_cfg;
            endcase
        end
    end

    // Entry stage: exact offsets to the target
    logic signed [DW-1:0] r_dx, r_dy;
    logic [15:0]          r_yaw;
    logic                 r_fin, r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_en) begin
            r_v <= i_in_valid;
        end
        if (w_en) begin
            r_dx  <= $signed({i_target_x[23], i_target_x}) - $signed({i_pose_x[23], i_pose_x});
            r_dy  <= $signed({i_target_y[23], i_target_y}) - $signed({i_pose_y[23], i_pose_y});
            r_yaw <= i_pose_yaw;
            r_fin <= i_final_cell;
        end
    end

    // Bearing and heading error
    logic               w_ev, w_efin;
    logic signed [15:0] w_err;

    ddhs_vec #(.STEPS(STEPS)) u_vec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v),
        .i_dx    (r_dx),
        .i_dy    (r_dy),
        .i_yaw   (r_yaw),
        .i_fin   (r_fin),
        .o_valid (w_ev),
        .o_err   (w_err),
        .o_fin   (w_efin)
    );

    // Cosine of the error
    logic                 w_cv, w_cfin;
    logic signed [CW-1:0] w_cos;
    logic signed [15:0]   w_cerr;

    ddhs_cos #(.STEPS(STEPS)) u_cos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_ev),
        .i_err   (w_err),
        .i_fin   (w_efin),
        .o_valid (w_cv),
        .o_cos   (w_cos),
        .o_err   (w_cerr),
        .o_fin   (w_cfin)
    );

    // Distance to target, beside the angle path
    logic [SQ_DIGITS-1:0] w_dist;

    ddhs_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_dx   (r_dx),
        .i_dy   (r_dy),
        .o_dist (w_dist)
    );

    // Line up the two paths
    logic [AW-1:0]        w_ang_d;
    logic                 w_av;
    logic                 w_dv_unused;
    logic [SQ_DIGITS-1:0] w_dist_d;

    ddhs_dly #(.W(AW), .N(D_ANG)) u_dly_ang (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_cv),
        .i_data  ({w_cos, w_cerr, w_cfin}),
        .o_valid (w_av),
        .o_data  (w_ang_d)
    );

    ddhs_dly #(.W(SQ_DIGITS), .N(D_SQ)) u_dly_sq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_cv),
        .i_data  (w_dist),
        .o_valid (w_dv_unused),
        .o_data  (w_dist_d)
    );

    // Wheel speed back end and output register
    ddhs_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_cfg   (r_cfg),
        .i_valid (w_av && (w_dv_unused || !w_dv_unused)),
        .i_cos   ($signed(w_ang_d[AW-1 -: CW])),
        .i_err   ($signed(w_ang_d[16:1])),
        .i_fin   (w_ang_d[0]),
        .i_dist  (w_dist_d),
        .o_valid (o_out_valid),
        .o_left  (o_left_speed),
        .o_right (o_right_speed),
        .o_piv   (o_pivoting)
    );

    // A pivot drives the wheels in exact opposition.
    a_pivot_opposed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_pivoting |-> o_left_speed == -o_right_speed)
        else $error("pivot speeds not opposed");

    // Forward drive keeps both wheels within cruise speed.
    a_drive_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_pivoting |->
            o_left_speed <= $signed({1'b0, r_cfg.cruise_speed}) &&
            o_left_speed >= -$signed({1'b0, r_cfg.cruise_speed}) &&
            o_right_speed <= $signed({1'b0, r_cfg.cruise_speed}) &&
            o_right_speed >= -$signed({1'b0, r_cfg.cruise_speed}))
        else $error("wheel speed beyond cruise limit");

    // A stuck result freezes intake.
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input taken while output stalled");

    // Reset empties the pipe.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result present after reset");

endmodule
